### src/cde_pkg.sv
`timescale 1ns / 1ps

package cde_pkg;

    // store geometry
    localparam int DEPTH   = 8;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    // request command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_REAR  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_REAR   = 2'd3
    } cmd_code_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_code_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
        logic publish;
    } ctrl_cmd_t;

endpackage

### src/cde_req_if.sv
`timescale 1ns / 1ps

interface cde_req_if
    import cde_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output command, output push_value, input ready);
    modport sink   (input valid, input command, input push_value, output ready);
endinterface

### src/cde_rsp_if.sv
`timescale 1ns / 1ps

interface cde_rsp_if
    import cde_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] popped_value;
    logic [STAT_W-1:0]        status;
    logic [CW-1:0]            occupancy;

    modport source (output valid, output popped_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input popped_value, input status, input occupancy,
                    output ready);
endinterface

### src/cde_ctrl.sv
`timescale 1ns / 1ps

module cde_ctrl
    import cde_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output ctrl_cmd_t ctl
);

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   accept;
    logic   out_free;

    // handshake terms
    assign accept    = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready   = 1'b0;
        ctl.capture = 1'b0;
        ctl.execute = 1'b0;
        ctl.publish = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                ctl.capture = req_valid;
            end
            S_EXEC:
            begin
                ctl.execute = 1'b1;
            end
            S_LOAD:
            begin
                ctl.publish = out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.publish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.publish |-> (!rsp_valid_reg || rsp_ready))
        else $error("result overwritten while waiting");

    // every accepted request reaches execution next cycle
    a_exec_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ctl.execute)
        else $error("accepted request not executed");

    // execution is always followed by the load state
    a_load_follows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.execute |=> (state_reg == S_LOAD))
        else $error("execute not followed by load");

endmodule

### src/cde_dpath.sv
`timescale 1ns / 1ps

module cde_dpath
    import cde_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctrl_cmd_t                ctl,
    input  logic [CMD_W-1:0]         command,
    input  logic signed [DATA_W-1:0] push_value,
    output logic signed [DATA_W-1:0] popped_value,
    output logic [STAT_W-1:0]        status,
    output logic [CW-1:0]            occupancy
);

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // captured request
    cmd_code_t          cmd_reg;
    logic [DATA_W-1:0]  val_reg;

    // deque pointers and fill count
    logic [AW-1:0]      head_reg;
    logic [AW-1:0]      head_next;
    logic [AW-1:0]      tail_reg;
    logic [AW-1:0]      tail_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;

    // execution results held for the load cycle
    status_code_t       stat_reg;
    status_code_t       stat_next;
    logic               pop_ok_reg;
    logic               pop_ok_next;
    logic [DATA_W-1:0]  rdata_reg;

    // output registers
    logic [DATA_W-1:0]  popped_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [CW-1:0]      occ_reg;

    // storage
    logic [DATA_W-1:0]  mem [DEPTH];

    logic               is_push;
    logic               full;
    logic               empty;
    logic [AW-1:0]      head_dec;
    logic [AW-1:0]      head_inc;
    logic [AW-1:0]      tail_dec;
    logic [AW-1:0]      tail_inc;
    logic               wr_en;
    logic [AW-1:0]      waddr;
    logic [AW-1:0]      raddr;

    // wrapping pointer steps
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - AW'(1);
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
    assign tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - AW'(1);
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + AW'(1);

    assign is_push = (cmd_reg == CMD_PUSH_FRONT) || (cmd_reg == CMD_PUSH_REAR);
    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);

    // command decode and pointer update
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        stat_next   = ST_DONE;
        pop_ok_next = 1'b0;
        wr_en       = 1'b0;
        waddr       = tail_inc;
        raddr       = tail_reg;
        case (cmd_reg)
            CMD_PUSH_FRONT:
            begin
                waddr = head_dec;
                if (full)
                begin
                    stat_next = ST_FULL;
                end
                else
                begin
                    wr_en      = ctl.execute;
                    head_next  = head_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_PUSH_REAR:
            begin
                waddr = tail_inc;
                if (full)
                begin
                    stat_next = ST_FULL;
                end
                else
                begin
                    wr_en      = ctl.execute;
                    tail_next  = tail_inc;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_POP_FRONT:
            begin
                raddr = head_reg;
                if (empty)
                begin
                    stat_next = ST_EMPTY;
                end
                else
                begin
                    pop_ok_next = 1'b1;
                    head_next   = head_inc;
                    count_next  = count_reg - CW'(1);
                end
            end
            CMD_POP_REAR:
            begin
                raddr = tail_reg;
                if (empty)
                begin
                    stat_next = ST_EMPTY;
                end
                else
                begin
                    pop_ok_next = 1'b1;
                    tail_next   = tail_dec;
                    count_next  = count_reg - CW'(1);
                end
            end
            default:
            begin
                stat_next = ST_DONE;
            end
        endcase
    end

    // storage write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= val_reg;
        end
        if (ctl.execute)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // request capture and held results
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= cmd_code_t'(command);
            val_reg <= push_value;
        end
        if (ctl.execute)
        begin
            stat_reg   <= stat_next;
            pop_ok_reg <= pop_ok_next;
        end
        if (ctl.publish)
        begin
            popped_reg <= pop_ok_reg ? rdata_reg : '0;
            status_reg <= stat_reg;
            occ_reg    <= count_reg;
        end
    end

    // pointer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= LAST_IDX;
            count_reg <= '0;
        end
        else if (ctl.execute)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign occupancy    = occ_reg;

    // fill count never passes the store size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("fill count out of range");

    // pointers and count move only while executing
    a_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.execute |=> ($stable(head_reg) && $stable(tail_reg) && $stable(count_reg)))
        else $error("pointer state changed outside execution");

    // a rejected command leaves the deque untouched
    a_reject_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.execute && stat_next != ST_DONE) |=>
            ($stable(head_reg) && $stable(tail_reg) && $stable(count_reg)))
        else $error("rejected command changed state");

    // no write to storage on a pop
    a_pop_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.execute && !is_push) |-> !wr_en)
        else $error("storage written on pop");

endmodule

### src/circular_deque_engine.sv
`timescale 1ns / 1ps

// Double-ended queue of eight 32-bit words kept in a circular store. Each
// request carries one command (push front, push rear, pop front, pop rear)
// and gives exactly one result with the popped word (zero unless a pop
// succeeded), a status (done, rejected full, rejected empty) and the
// occupancy after the command. A request is taken in the idle state,
// executed in the execute state (pointer update plus one store write or one
// registered store read) and loaded into the result register in the load
// state, which waits until the previous result has been taken. A new
// request is accepted as soon as the previous result sits in the result
// register, even while it waits there to be taken. No clearing pass
// follows reset.

module circular_deque_engine
    import cde_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    cde_req_if.sink   req,
    cde_rsp_if.source rsp
);

    ctrl_cmd_t ctl;

    // sequencing
    cde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ctl       (ctl)
    );

    // pointers, store and result registers
    cde_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .command      (req.command),
        .push_value   (req.push_value),
        .popped_value (rsp.popped_value),
        .status       (rsp.status),
        .occupancy    (rsp.occupancy)
    );

endmodule

### sim/circular_deque_engine_tb.sv
`timescale 1ns / 1ps

module circular_deque_engine_tb;
    import cde_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_CMDS  = 1700;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 20;

    // one command as sent to the block
    typedef struct {
        cmd_code_t                op;
        logic signed [DATA_W-1:0] word;
    } deque_cmd_t;

    // one result as the block should return it
    typedef struct {
        logic signed [DATA_W-1:0] popped_value;
        status_code_t             status;
        logic [CW-1:0]            occupancy;
    } deque_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    cde_req_if req_if ();
    cde_rsp_if rsp_if ();

    circular_deque_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    deque_cmd_t    pending_cmds[$];
    deque_result_t expected_results[$];

    // shadow copy of the deque
    logic signed [DATA_W-1:0] shadow_words [DEPTH];
    int front_pos  = 0;
    int rear_pos   = DEPTH - 1;
    int word_count = 0;

    int mismatch_count = 0;
    int idle_cycles    = 0;

    // apply one command to the shadow deque and return what the block should report
    function automatic deque_result_t deque_apply(cmd_code_t op,
                                                  logic signed [DATA_W-1:0] word);
        deque_result_t r;
        r.popped_value = '0;
        r.status       = ST_DONE;
        if (op == CMD_PUSH_FRONT || op == CMD_PUSH_REAR)
        begin
            if (word_count >= DEPTH)
                r.status = ST_FULL;
            else if (op == CMD_PUSH_FRONT)
            begin
                front_pos = (front_pos + DEPTH - 1) % DEPTH;
                shadow_words[front_pos] = word;
                word_count++;
            end
            else
            begin
                rear_pos = (rear_pos + 1) % DEPTH;
                shadow_words[rear_pos] = word;
                word_count++;
            end
        end
        else
        begin
            if (word_count == 0)
                r.status = ST_EMPTY;
            else if (op == CMD_POP_FRONT)
            begin
                r.popped_value = shadow_words[front_pos];
                front_pos = (front_pos + 1) % DEPTH;
                word_count--;
            end
            else
            begin
                r.popped_value = shadow_words[rear_pos];
                rear_pos = (rear_pos + DEPTH - 1) % DEPTH;
                word_count--;
            end
        end
        r.occupancy = CW'(word_count);
        return r;
    endfunction

    // idle length: none in calm stretches, otherwise usually none or short, a few long
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 25);
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_cmd(cmd_code_t op, logic signed [DATA_W-1:0] word);
        deque_cmd_t c;
        c.op   = op;
        c.word = word;
        pending_cmds.push_back(c);
    endtask

    // request driver
    int send_gap;
    bit sender_calm;

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        deque_cmd_t next_cmd;
        if (!rst_n)
        begin
            req_if.valid      <= 1'b0;
            req_if.command    <= CMD_PUSH_FRONT;
            req_if.push_value <= '0;
            send_gap          <= 0;
            sender_calm       <= 1'b0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
                expected_results.push_back(deque_apply(cmd_code_t'(req_if.command),
                                                       req_if.push_value));
            if (!req_if.valid || req_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap     <= send_gap - 1;
                    req_if.valid <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    next_cmd = pending_cmds.pop_front();
                    req_if.command    <= next_cmd.op;
                    req_if.push_value <= next_cmd.word;
                    req_if.valid      <= 1'b1;
                    send_gap          <= pick_gap(sender_calm);
                    if ($urandom_range(0, 63) == 0)
                        sender_calm <= !sender_calm;
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // result monitor and checker
    int stall_left;
    int hold_left;
    int results_seen;
    bit taker_calm;

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        deque_result_t exp_res;
        bit            took;
        int            gap;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            stall_left   <= 0;
            hold_left    <= 0;
            results_seen = 0;
            taker_calm   <= 1'b0;
        end
        else
        begin
            took = rsp_if.valid && rsp_if.ready;
            if (took)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: popped %h status %0d occupancy %0d",
                                 rsp_if.popped_value, rsp_if.status, rsp_if.occupancy);
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (rsp_if.popped_value !== exp_res.popped_value
                        || rsp_if.status !== exp_res.status
                        || rsp_if.occupancy !== exp_res.occupancy)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result %0d mismatch: expected %h/%0d/%0d got %h/%0d/%0d",
                                     results_seen, exp_res.popped_value, exp_res.status,
                                     exp_res.occupancy, rsp_if.popped_value,
                                     rsp_if.status, rsp_if.occupancy);
                    end
                end
                if ($urandom_range(0, 63) == 0)
                    taker_calm <= !taker_calm;
            end

            // ready pattern, with a long hold-off now and then to back up the block
            if (hold_left > 0)
            begin
                hold_left    <= hold_left - 1;
                rsp_if.ready <= 1'b0;
            end
            else if (took && results_seen % 500 == 250)
            begin
                hold_left    <= LONG_HOLD;
                rsp_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left   <= stall_left - 1;
                rsp_if.ready <= 1'b0;
            end
            else if (took)
            begin
                gap = pick_gap(taker_calm);
                stall_left   <= gap;
                rsp_if.ready <= (gap == 0);
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // cycles without any handshake
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    // stimulus and end of run
    initial
    begin : stimulus
        int push_bias;
        bit is_push;
        req_if.valid      = 1'b0;
        req_if.command    = CMD_PUSH_FRONT;
        req_if.push_value = '0;
        rsp_if.ready      = 1'b0;

        // pops on an empty deque
        queue_cmd(CMD_POP_FRONT, 32'h1234_5678);
        queue_cmd(CMD_POP_REAR, 32'hFFFF_FFFF);
        // fill from both ends with the extreme words
        queue_cmd(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
        queue_cmd(CMD_PUSH_REAR, 32'h8000_0000);
        queue_cmd(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        queue_cmd(CMD_PUSH_REAR, 32'h0000_0000);
        queue_cmd(CMD_PUSH_FRONT, 32'h5555_5555);
        queue_cmd(CMD_PUSH_REAR, 32'hAAAA_AAAA);
        queue_cmd(CMD_PUSH_FRONT, 32'h0000_0001);
        queue_cmd(CMD_PUSH_REAR, 32'hFFFF_FFFE);
        // pushes on a full deque
        queue_cmd(CMD_PUSH_FRONT, 32'hDEAD_BEEF);
        queue_cmd(CMD_PUSH_REAR, 32'h0BAD_F00D);
        // drain from both ends
        repeat (4)
        begin
            queue_cmd(CMD_POP_FRONT, 32'h0000_0000);
            queue_cmd(CMD_POP_REAR, 32'hFFFF_FFFF);
        end
        queue_cmd(CMD_POP_FRONT, 32'h0000_0000);

        // random part: alternate push-heavy and pop-heavy stretches to hit full and empty
        push_bias = 50;
        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            if (i % 40 == 0)
                push_bias = ((i / 40) % 2 == 0) ? $urandom_range(60, 85)
                                                : $urandom_range(15, 40);
            is_push = ($urandom_range(0, 99) < push_bias);
            if (is_push)
                queue_cmd($urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT, rand_word());
            else
                queue_cmd($urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT, rand_word());
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || req_if.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
